// File: design/lpfr_pkg.sv
// Shared types, constants and helpers for the LRU page frame replacer.
// Used by lpfr_ctrl and lru_page_frame_replacer_unit; depends on nothing.

package lpfr_pkg;

  // Number of page frames held in the frame memory.
  localparam int FRAMES = 16;

  // Frame index and recency rank share one width; the count can hold FRAMES itself.
  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);

  // Fixed field widths of the item and result beats.
  localparam int PAGE_W  = 16;
  localparam int FIU_W   = 5;
  localparam int FIDX_W  = 4;
  localparam int FAULT_W = 16;

  // One memory word holds a frame's page number above its recency rank.
  localparam int ENTRY_W = PAGE_W + IDX_W;

  localparam logic [IDX_W-1:0]   RANK_MAX  = IDX_W'(FRAMES - 1);
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;
  localparam logic [FIU_W-1:0]   FIU_RESET = FIU_W'(4);

  // Configuration port layout: one 32-bit register per word.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = REG_IDX_W'(0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } lpfr_state_t;

  // Request from the controller to the frame memory.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } lpfr_mem_req_t;

  // One finished result.
  typedef struct packed {
    logic               page_fault;
    logic [FIDX_W-1:0]  frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_count;
  } lpfr_result_t;

  // A count of zero acts as one frame, a count above FRAMES acts as FRAMES.
  function automatic logic [CNT_W-1:0] clamp_frames(input logic [FIU_W-1:0] fiu);
    logic [CNT_W-1:0] n;
    if (fiu == '0) begin
      n = CNT_W'(1);
    end else if (32'(fiu) > FRAMES) begin
      n = CNT_W'(FRAMES);
    end else begin
      n = CNT_W'(fiu);
    end
    return n;
  endfunction

endpackage

// File: design/lru_page_frame_replacer_unit.sv
// Flow: an accepted item runs a scan sweep over the first n frames of the frame memory,
// a decide state and an update sweep, where n is the clamped frame count; its result is
// then loaded into the output register. One item is in flight at a time: a new one is
// taken only back in idle; a full output register holds the sequencer in its last state.
// Reset: synchronous, active low; all frames empty, fault count zero, frames_in_use = 4.
// Depends on lpfr_pkg, lpfr_ram and lpfr_ctrl.

module lru_page_frame_replacer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lpfr_pkg::PAGE_W-1:0]       in_page_number,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_page_fault,
  output logic [lpfr_pkg::FIDX_W-1:0]       out_frame_index,
  output logic                              out_evicted_valid,
  output logic [lpfr_pkg::PAGE_W-1:0]       out_evicted_page,
  output logic [lpfr_pkg::FAULT_W-1:0]      out_fault_count,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lpfr_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [lpfr_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [lpfr_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  logic [lpfr_pkg::FIU_W-1:0]     frames_in_use_r;
  logic [lpfr_pkg::REG_IDX_W-1:0] reg_idx;
  lpfr_pkg::lpfr_mem_req_t        mem_req;
  logic [lpfr_pkg::ENTRY_W-1:0]   mem_rdata;
  logic                           res_valid;
  logic                           res_ready;
  lpfr_pkg::lpfr_result_t         res;
  logic                           out_valid_r;
  lpfr_pkg::lpfr_result_t         out_r;

  // Configuration register.
  assign reg_idx    = cfg_paddr[lpfr_pkg::CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= lpfr_pkg::FIU_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && (reg_idx == lpfr_pkg::REG_FRAMES_IN_USE)) begin
      frames_in_use_r <= cfg_pwdata[lpfr_pkg::FIU_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == lpfr_pkg::REG_FRAMES_IN_USE) begin
      cfg_prdata = lpfr_pkg::CFG_DATA_W'(frames_in_use_r);
    end
  end

  // Frame memory: page number and recency rank per frame.
  lpfr_ram #(
    .WIDTH (lpfr_pkg::ENTRY_W),
    .DEPTH (lpfr_pkg::FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  lpfr_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_page_number (in_page_number),
    .in_ready       (in_ready),
    .frames_in_use  (frames_in_use_r),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready)
  );

  // Output register: holds a result beat until it is taken.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_page_fault    = out_r.page_fault;
  assign out_frame_index   = out_r.frame_index;
  assign out_evicted_valid = out_r.evicted_valid;
  assign out_evicted_page  = out_r.evicted_page;
  assign out_fault_count   = out_r.fault_count;

`ifndef NO_ASSERTIONS
  // An eviction only happens on a fault.
  a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_valid |-> out_page_fault)
    else $error("eviction reported without a page fault");

  // Without an eviction the evicted page reads as zero.
  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> (out_evicted_page == '0))
    else $error("evicted page nonzero without an eviction");

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");
`endif

endmodule

// File: design/lpfr_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package dependencies.

module lpfr_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/lpfr_ctrl.sv
// Sequencer of the LRU page frame replacer: scans the frame memory, picks the frame,
// then sweeps it again to age ranks. Depends on lpfr_pkg.

module lpfr_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [lpfr_pkg::PAGE_W-1:0]   in_page_number,
  output logic                          in_ready,
  input  logic [lpfr_pkg::FIU_W-1:0]    frames_in_use,
  output lpfr_pkg::lpfr_mem_req_t       mem_req,
  input  logic [lpfr_pkg::ENTRY_W-1:0]  mem_rdata,
  output logic                          res_valid,
  output lpfr_pkg::lpfr_result_t        res,
  input  logic                          res_ready
);

  localparam int IDX_W  = lpfr_pkg::IDX_W;
  localparam int CNT_W  = lpfr_pkg::CNT_W;
  localparam int PAGE_W = lpfr_pkg::PAGE_W;

  lpfr_pkg::lpfr_state_t state_r, state_nxt;

  logic                   accept;
  logic [CNT_W-1:0]       n_r;
  logic [PAGE_W-1:0]      page_r;
  logic [lpfr_pkg::FRAMES-1:0] frame_valid_r;
  logic [lpfr_pkg::FAULT_W-1:0] faults_r;

  // Sweep counter and read pipeline.
  logic [IDX_W-1:0] issue_r;
  logic             issue_done_r;
  logic             issue_last;
  logic             start_pass;
  logic             rd_en;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_last_r;

  // Scan findings.
  logic              hit_found_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [IDX_W-1:0]  hit_rank_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [IDX_W-1:0]  best_rank_r;
  logic [PAGE_W-1:0] best_page_r;

  // Decision for the update pass.
  logic             fault_r;
  logic             evict_r;
  logic             age_all_r;
  logic [IDX_W-1:0] j_r;
  logic [IDX_W-1:0] old_rank_r;

  logic [PAGE_W-1:0] rd_page;
  logic [IDX_W-1:0]  rd_rank;
  logic              scan_beat;
  logic              upd_beat;
  logic              age_it;

  assign rd_page = mem_rdata[lpfr_pkg::ENTRY_W-1:IDX_W];
  assign rd_rank = mem_rdata[IDX_W-1:0];

  assign accept     = in_valid && in_ready;
  assign start_pass = accept || (state_r == lpfr_pkg::ST_DECIDE);
  assign issue_last = (CNT_W'(issue_r) == (n_r - CNT_W'(1)));
  assign rd_en      = ((state_r == lpfr_pkg::ST_SCAN) || (state_r == lpfr_pkg::ST_UPDATE))
                      && !issue_done_r;
  assign scan_beat  = (state_r == lpfr_pkg::ST_SCAN) && rd_vld_r;
  assign upd_beat   = (state_r == lpfr_pkg::ST_UPDATE) && rd_vld_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpfr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      lpfr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = lpfr_pkg::ST_SCAN;
        end
      end
      lpfr_pkg::ST_SCAN: begin
        if (rd_vld_r && rd_last_r) begin
          state_nxt = lpfr_pkg::ST_DECIDE;
        end
      end
      lpfr_pkg::ST_DECIDE: begin
        state_nxt = lpfr_pkg::ST_UPDATE;
      end
      lpfr_pkg::ST_UPDATE: begin
        if (rd_vld_r && rd_last_r) begin
          state_nxt = lpfr_pkg::ST_DONE;
        end
      end
      lpfr_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = lpfr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lpfr_pkg::ST_IDLE;
    endcase
  end

  // Sweep counter: one frame address per cycle, restarted for each pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r      <= '0;
      issue_done_r <= 1'b0;
      rd_vld_r     <= 1'b0;
    end else begin
      if (start_pass) begin
        issue_r      <= '0;
        issue_done_r <= 1'b0;
      end else if (rd_en) begin
        issue_r      <= issue_last ? issue_r : IDX_W'(issue_r + 1'b1);
        issue_done_r <= issue_last;
      end
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= issue_r;
    rd_last_r <= issue_last;
  end

  // Latch the request and the clamped frame count on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      page_r <= in_page_number;
      n_r    <= lpfr_pkg::clamp_frames(frames_in_use);
    end
  end

  // Scan pass: first match, first empty frame and oldest frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (accept) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (scan_beat) begin
      if (frame_valid_r[rd_idx_r] && (rd_page == page_r) && !hit_found_r) begin
        hit_found_r <= 1'b1;
      end
      if (!frame_valid_r[rd_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_beat) begin
      if (frame_valid_r[rd_idx_r] && (rd_page == page_r) && !hit_found_r) begin
        hit_idx_r  <= rd_idx_r;
        hit_rank_r <= rd_rank;
      end
      if (!frame_valid_r[rd_idx_r] && !free_found_r) begin
        free_idx_r <= rd_idx_r;
      end
      // Strictly larger rank wins, so ties keep the lower frame.
      if ((rd_idx_r == '0) || (rd_rank > best_rank_r)) begin
        best_idx_r  <= rd_idx_r;
        best_rank_r <= rd_rank;
        best_page_r <= rd_page;
      end
    end
  end

  // Decide the frame: hit, else empty frame, else least recently used.
  always_ff @(posedge clk) begin
    if (state_r == lpfr_pkg::ST_DECIDE) begin
      priority if (hit_found_r) begin
        j_r        <= hit_idx_r;
        old_rank_r <= hit_rank_r;
        age_all_r  <= 1'b0;
        fault_r    <= 1'b0;
        evict_r    <= 1'b0;
      end else if (free_found_r) begin
        j_r        <= free_idx_r;
        old_rank_r <= '0;
        age_all_r  <= 1'b1;
        fault_r    <= 1'b1;
        evict_r    <= 1'b0;
      end else begin
        j_r        <= best_idx_r;
        old_rank_r <= best_rank_r;
        age_all_r  <= 1'b0;
        fault_r    <= 1'b1;
        evict_r    <= 1'b1;
      end
    end
  end

  // Update pass: the chosen frame becomes most recent, newer valid frames age.
  assign age_it = frame_valid_r[rd_idx_r] && (age_all_r || (rd_rank < old_rank_r))
                  && (rd_rank != lpfr_pkg::RANK_MAX);

  always_comb begin
    mem_req.re    = rd_en;
    mem_req.raddr = issue_r;
    mem_req.waddr = rd_idx_r;
    mem_req.we    = 1'b0;
    mem_req.wdata = {page_r, IDX_W'(0)};
    if (upd_beat) begin
      if (rd_idx_r == j_r) begin
        mem_req.we = 1'b1;
      end else if (age_it) begin
        mem_req.we    = 1'b1;
        mem_req.wdata = {rd_page, IDX_W'(rd_rank + 1'b1)};
      end
    end
  end

  // Write and read never touch the same frame in one cycle, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      faults_r      <= '0;
    end else if (upd_beat && rd_last_r) begin
      frame_valid_r[j_r] <= 1'b1;
      if (fault_r && (faults_r != lpfr_pkg::FAULT_MAX)) begin
        faults_r <= faults_r + 1'b1;
      end
    end
  end

  // Result beat.
  always_comb begin
    res.page_fault    = fault_r;
    res.frame_index   = lpfr_pkg::FIDX_W'(j_r);
    res.evicted_valid = evict_r;
    res.evicted_page  = evict_r ? best_page_r : '0;
    res.fault_count   = faults_r;
  end

endmodule
